// ----- rtl/dha_pkg.sv -----
// Package for the displacement histogram accumulator.
// Holds action codes, controller state type, command/status structs and constants.
`default_nettype none
package dha_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_END    = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        MODE_3D = 3'd0,
        MODE_X  = 3'd1,
        MODE_Y  = 3'd2,
        MODE_Z  = 3'd3,
        MODE_XY = 3'd4
    } mode_t;

    localparam logic [1:0] REG_BOX   = 2'd0;
    localparam logic [1:0] REG_BINW  = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;
    localparam logic [1:0] REG_FAST  = 2'd3;

    localparam int unsigned SPECIES = 5;

    localparam logic [15:0] Q_THR0 = 16'd768;
    localparam logic [15:0] Q_THR1 = 16'd1792;
    localparam logic [15:0] Q_THR2 = 16'd2304;
    localparam logic [15:0] Q_THR3 = 16'd2816;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIST,
        ST_SQ,
        ST_SUM,
        ST_SQRT,
        ST_DIV,
        ST_HRD,
        ST_HWR,
        ST_OUT,
        ST_EOUT,
        ST_RRD,
        ST_ROUT
    } state_t;

    typedef struct packed {
        logic load;
        logic disp;
        logic square;
        logic sum;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic hist_rd;
        logic hist_wr;
        logic clr_step;
        logic end_clear;
        logic out_load_sample;
        logic out_load_end;
        logic out_load_read;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic clr_done;
        logic end_last;
    } sts_t;

    function automatic logic [2:0] species_of(input logic [15:0] q);
        logic [2:0] s;
        begin
            if (q < Q_THR0)      s = 3'd0;
            else if (q < Q_THR1) s = 3'd1;
            else if (q < Q_THR2) s = 3'd2;
            else if (q < Q_THR3) s = 3'd3;
            else                 s = 3'd4;
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/dha_ctrl.sv -----
// Controller state machine for the displacement histogram accumulator.
// Depends on dha_pkg for state, command and status types.
`default_nettype none
module dha_ctrl
    import dha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] action,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire sts_t       sts,
    output cmd_t            cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    unique case (action)
                        ACT_SAMPLE: state_next = ST_DIST;
                        ACT_END:    state_next = ST_EOUT;
                        ACT_READ:   state_next = ST_RRD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIST:
            begin
                cmd.disp   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum        = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_HRD;
            end
            ST_HRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.hist_wr = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.out_load_sample = 1'b1;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            ST_EOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load_end = 1'b1;
                    out_valid_next   = 1'b1;
                    if (sts.end_last)
                    begin
                        cmd.end_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_RRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = ST_ROUT;
            end
            ST_ROUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.out_load_read = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !out_valid_reg)
        else $error("result during clearing");
    a_sqrt_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT && sts.sqrt_done) |=> (state_reg == ST_DIV))
        else $error("divider not started");

endmodule
`default_nettype wire

// ----- rtl/dha_datapath.sv -----
// Datapath: displacement, squares, square root, bin divider, sums and histogram memory.
// Depends on dha_pkg for command/status types, codes and species thresholds.
`default_nettype none
module dha_datapath
    import dha_pkg::*;
#(
    parameter int BINS = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] start_x,
    input  wire logic [31:0] start_y,
    input  wire logic [31:0] start_z,
    input  wire logic [31:0] end_x,
    input  wire logic [31:0] end_y,
    input  wire logic [31:0] end_z,
    input  wire logic [15:0] charge_q,
    input  wire logic [2:0]  read_species,
    input  wire logic [5:0]  read_bin,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output logic [2:0]       species,
    output logic [63:0]      sq_distance,
    output logic [5:0]       bin_index,
    output logic             binned,
    output logic             accumulated,
    output logic [63:0]      value,
    output logic             last
);

    localparam int DEPTH = SPECIES * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (BINS > 1) ? $clog2(BINS) : 1;

    logic [30:0] box_reg, binw_reg, fast_reg;
    logic [2:0]  mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg  <= '0;
            binw_reg <= '0;
            mode_reg <= '0;
            fast_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX:  box_reg  <= cfg_data;
                REG_BINW: binw_reg <= cfg_data;
                REG_MODE: mode_reg <= cfg_data[2:0];
                REG_FAST: fast_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    logic [31:0] sx_reg, sy_reg, sz_reg, ex_reg, ey_reg, ez_reg;
    logic [2:0]  sp_reg;
    logic [2:0]  rsp_reg;
    logic [5:0]  rbin_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg   <= start_x;
            sy_reg   <= start_y;
            sz_reg   <= start_z;
            ex_reg   <= end_x;
            ey_reg   <= end_y;
            ez_reg   <= end_z;
            sp_reg   <= species_of(charge_q);
            rsp_reg  <= read_species;
            rbin_reg <= read_bin;
        end
    end

    function automatic logic [33:0] axis_dist(input logic [31:0] s, input logic [31:0] e,
                                              input logic [30:0] b);
        logic signed [34:0] d, dl, dh;
        logic [34:0] m, ml, mh;
        begin
            d  = 35'(signed'(e)) - 35'(signed'(s));
            dl = d - 35'(signed'({1'b0, b}));
            dh = d + 35'(signed'({1'b0, b}));
            m  = d[34]  ? 35'(-d)  : 35'(d);
            ml = dl[34] ? 35'(-dl) : 35'(dl);
            mh = dh[34] ? 35'(-dh) : 35'(dh);
            if (ml < m) m = ml;
            if (mh < m) m = mh;
            return m[33:0];
        end
    endfunction

    logic [33:0] dx_reg, dy_reg, dz_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.disp)
        begin
            dx_reg <= axis_dist(sx_reg, ex_reg, box_reg);
            dy_reg <= axis_dist(sy_reg, ey_reg, box_reg);
            dz_reg <= axis_dist(sz_reg, ez_reg, box_reg);
        end
    end

    function automatic logic [63:0] sq_sat(input logic [33:0] x);
        logic [63:0] p;
        begin
            p = x[31:0] * x[31:0];
            return (x[33:32] != 2'b00) ? '1 : p;
        end
    endfunction

    logic [63:0] qx_reg, qy_reg, qz_reg;
    logic [61:0] fsq_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            qx_reg  <= sq_sat(dx_reg);
            qy_reg  <= sq_sat(dy_reg);
            qz_reg  <= sq_sat(dz_reg);
            fsq_reg <= fast_reg * fast_reg;
        end
    end

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        end
    endfunction

    logic [63:0] sq_c, sq_reg;
    always_comb
    begin
        case (mode_reg)
            MODE_X:  sq_c = qx_reg;
            MODE_Y:  sq_c = qy_reg;
            MODE_Z:  sq_c = qz_reg;
            MODE_XY: sq_c = add_sat(qx_reg, qy_reg);
            default: sq_c = add_sat(add_sat(qx_reg, qy_reg), qz_reg);
        endcase
    end

    logic        acc_reg;
    logic [63:0] sums_reg [SPECIES];
    logic [2:0]  eidx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sq_reg  <= sq_c;
            acc_reg <= sq_c > {2'b00, fsq_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SPECIES; i++)
                sums_reg[i] <= '0;
        end
        else if (cmd.end_clear)
        begin
            for (int i = 0; i < SPECIES; i++)
                sums_reg[i] <= '0;
        end
        else if (cmd.hist_wr && acc_reg)
        begin
            sums_reg[sp_reg] <= add_sat(sums_reg[sp_reg], sq_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eidx_reg <= '0;
        else if (cmd.out_load_end)
            eidx_reg <= (cmd.end_clear) ? 3'd0 : eidx_reg + 3'd1;
    end
    assign sts.end_last = (eidx_reg == 3'(SPECIES - 1));

    // square root, one result bit per cycle
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    logic [5:0]  sqc_reg;
    logic [65:0] trial;
    logic [65:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[63:0], 2'b00};
        trial  = {32'd0, root_reg, 2'b01};
    end
    logic [63:0] sqv_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            sqc_reg  <= 6'd32;
            sqv_reg  <= sq_c;
        end
        else if (cmd.sqrt_step && sqc_reg != 6'd0)
        begin
            if ((rem_sh | {64'd0, sqv_reg[63:62]}) >= trial)
            begin
                rem_reg  <= 64'((rem_sh | {64'd0, sqv_reg[63:62]}) - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= 64'(rem_sh | {64'd0, sqv_reg[63:62]});
                root_reg <= {root_reg[30:0], 1'b0};
            end
            sqv_reg <= {sqv_reg[61:0], 2'b00};
            sqc_reg <= sqc_reg - 6'd1;
        end
    end
    assign sts.sqrt_done = (sqc_reg == 6'd0);

    // restoring divider, root / bin width, one quotient bit per cycle
    logic [31:0] quo_reg;
    logic [31:0] drem_reg;
    logic [5:0]  dvc_reg;
    logic [32:0] dshift;
    logic        binok_reg;
    always_comb
    begin
        dshift = {drem_reg, quo_reg[31]};
    end
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg   <= root_reg;
            drem_reg  <= '0;
            dvc_reg   <= 6'd32;
            binok_reg <= ({1'b0, root_reg} < {2'b00, box_reg}) && (binw_reg != '0);
        end
        else if (cmd.div_step && dvc_reg != 6'd0)
        begin
            if (dshift >= {2'b00, binw_reg})
            begin
                drem_reg <= 32'(dshift - {2'b00, binw_reg});
                quo_reg  <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                drem_reg <= dshift[31:0];
                quo_reg  <= {quo_reg[30:0], 1'b0};
            end
            dvc_reg <= dvc_reg - 6'd1;
        end
    end
    assign sts.div_done = (dvc_reg == 6'd0);

    logic bin_hit;
    assign bin_hit = binok_reg && (quo_reg < 32'(BINS));

    // histogram memory, cleared by a sweep after reset
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] addr;
    logic          rd_ok;
    logic          rd_ok_reg;
    logic          rbin_sel_reg;
    logic          rbin_sel;

    assign rbin_sel = rbin_sel_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rbin_sel_reg <= 1'b0;
        else if (cmd.load)
            rbin_sel_reg <= (action == ACT_READ);
    end

    always_comb
    begin
        if (cmd.clr_step)
            addr = clr_reg;
        else if (rbin_sel)
            addr = AW'(rsp_reg) * AW'(BINS) + AW'(rbin_reg);
        else
            addr = AW'(sp_reg) * AW'(BINS) + AW'(quo_reg[BW-1:0]);
    end

    assign rd_ok = (rsp_reg < 3'(SPECIES)) && (32'(rbin_reg) < 32'(BINS));

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            mem[addr] <= '0;
        else if (cmd.hist_wr && bin_hit && rd_reg != '1)
            mem[addr] <= rd_reg + 32'd1;
        if (cmd.hist_rd)
        begin
            rd_reg    <= mem[addr];
            rd_ok_reg <= rd_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step && !sts.clr_done)
            clr_reg <= clr_reg + AW'(1);
    end
    assign sts.clr_done = (clr_reg == AW'(DEPTH - 1));

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_sample)
        begin
            species     <= sp_reg;
            sq_distance <= sq_reg;
            bin_index   <= bin_hit ? 6'(quo_reg) : 6'd0;
            binned      <= bin_hit;
            accumulated <= acc_reg;
            value       <= '0;
            last        <= 1'b1;
        end
        else if (cmd.out_load_end)
        begin
            species     <= eidx_reg;
            sq_distance <= '0;
            bin_index   <= '0;
            binned      <= 1'b0;
            accumulated <= 1'b0;
            value       <= sums_reg[eidx_reg];
            last        <= sts.end_last;
        end
        else if (cmd.out_load_read)
        begin
            species     <= rsp_reg;
            sq_distance <= '0;
            bin_index   <= rbin_reg;
            binned      <= 1'b0;
            accumulated <= 1'b0;
            value       <= rd_ok_reg ? {32'd0, rd_reg} : 64'd0;
            last        <= 1'b1;
        end
    end

    a_eidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load_end |-> (eidx_reg < 3'(SPECIES)))
        else $error("end index out of range");
    a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |=> !sts.sqrt_done)
        else $error("square root did not start");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider did not start");

endmodule
`default_nettype wire

// ----- rtl/displacement_histogram_accumulator_top.sv -----
// Top level of the displacement histogram accumulator.
// Instantiates dha_ctrl and dha_datapath; uses dha_pkg.
// A particle result passes through displacement, squares and sum, the bit-serial square
// root, the restoring bin divider and the histogram read-modify-write before it is valid.
// A read result follows a single histogram read; an end-of-configuration item gives one
// sum per cycle while the receiver takes each sum. The next item is taken only
// once the previous result has transferred.
// After reset a clearing pass zeroes all 5*BINS histogram words before items are taken.
`default_nettype none
module displacement_histogram_accumulator_top
    import dha_pkg::*;
#(
    parameter int BINS = 64
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] start_x,
    input  wire logic [31:0] start_y,
    input  wire logic [31:0] start_z,
    input  wire logic [31:0] end_x,
    input  wire logic [31:0] end_y,
    input  wire logic [31:0] end_z,
    input  wire logic [15:0] charge_q,
    input  wire logic [2:0]  read_species,
    input  wire logic [5:0]  read_bin,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       species,
    output logic [63:0]      sq_distance,
    output logic [5:0]       bin_index,
    output logic             binned,
    output logic             accumulated,
    output logic [63:0]      value,
    output logic             last
);

    cmd_t cmd;
    sts_t sts;

    dha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dha_datapath #(.BINS(BINS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .charge_q     (charge_q),
        .read_species (read_species),
        .read_bin     (read_bin),
        .cmd          (cmd),
        .sts          (sts),
        .species      (species),
        .sq_distance  (sq_distance),
        .bin_index    (bin_index),
        .binned       (binned),
        .accumulated  (accumulated),
        .value        (value),
        .last         (last)
    );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for displacement_histogram_accumulator_top: drives particle, end, read and no-op items
// over valid/ready, predicts every result with an in-bench model and checks each transfer.
// Depends on rtl/dha_pkg.sv and rtl/displacement_histogram_accumulator_top.sv.
`default_nettype none
module tb;
    import dha_pkg::*;

    localparam int NBINS = 64;
    localparam int QUIET_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  species;
        logic [63:0] sq_distance;
        logic [5:0]  bin_index;
        logic        binned;
        logic        accumulated;
        logic [63:0] value;
        logic        last;
    } msd_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_BOX;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_NONE;
    logic [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic [15:0] charge_q = '0;
    logic [2:0]  read_species = '0;
    logic [5:0]  read_bin = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  species;
    logic [63:0] sq_distance;
    logic [5:0]  bin_index;
    logic        binned;
    logic        accumulated;
    logic [63:0] value;
    logic        last;

    displacement_histogram_accumulator_top #(.BINS(NBINS)) i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [30:0] box_reg, binw_reg, fast_reg;
    logic [2:0]  mode_reg;
    logic [63:0] sq_sums [SPECIES];
    logic [31:0] hist_counts [SPECIES*NBINS];
    msd_result_t expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int samples_sent = 0, ends_sent = 0, reads_sent = 0, results_seen = 0;

    function automatic logic [63:0] min_image(input logic [31:0] s, input logic [31:0] e);
        logic signed [63:0] d, b, m, lo, hi;
        d = $signed({{32{e[31]}}, e}) - $signed({{32{s[31]}}, s});
        b = {33'd0, box_reg};
        m = d < 0 ? -d : d;
        lo = (d - b) < 0 ? -(d - b) : (d - b);
        hi = (d + b) < 0 ? -(d + b) : (d + b);
        if (lo < m) m = lo;
        if (hi < m) m = hi;
        return m;
    endfunction

    function automatic logic [63:0] square_sat(input logic [63:0] x);
        if (x[63:32] != 0) return '1;
        return x * x;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            logic [63:0] t;
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= {64'd0, v}) r = t;
        end
        return r;
    endfunction

    function automatic logic [2:0] charge_class(input logic [15:0] q);
        if (q < 16'd768) return 3'd0;
        if (q < 16'd1792) return 3'd1;
        if (q < 16'd2304) return 3'd2;
        if (q < 16'd2816) return 3'd3;
        return 3'd4;
    endfunction

    task automatic predict_item(input logic [1:0] act, input logic [31:0] sx, sy, sz,
                                input logic [31:0] ex, ey, ez, input logic [15:0] q,
                                input logic [2:0] rsp, input logic [5:0] rbin);
        msd_result_t r;
        logic [63:0] dx, dy, dz, sq, s, bin;
        logic [2:0] sp;
        r = '0;
        case (action_t'(act))
            ACT_SAMPLE:
            begin
                dx = min_image(sx, ex);
                dy = min_image(sy, ey);
                dz = min_image(sz, ez);
                sp = charge_class(q);
                case (mode_reg)
                    MODE_X:  sq = square_sat(dx);
                    MODE_Y:  sq = square_sat(dy);
                    MODE_Z:  sq = square_sat(dz);
                    MODE_XY: sq = add_sat(square_sat(dx), square_sat(dy));
                    default: sq = add_sat(add_sat(square_sat(dx), square_sat(dy)),
                                          square_sat(dz));
                endcase
                r.accumulated = sq > {33'd0, fast_reg} * {33'd0, fast_reg};
                if (r.accumulated) sq_sums[sp] = add_sat(sq_sums[sp], sq);
                s = floor_sqrt(sq);
                if (s < {33'd0, box_reg} && binw_reg != 0)
                begin
                    bin = s / {33'd0, binw_reg};
                    if (bin < NBINS)
                    begin
                        r.binned = 1'b1;
                        r.bin_index = bin[5:0];
                        if (hist_counts[sp*NBINS+bin] != '1)
                            hist_counts[sp*NBINS+bin]++;
                    end
                end
                r.species = sp;
                r.sq_distance = sq;
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            ACT_END:
            begin
                for (int k = 0; k < SPECIES; k++)
                begin
                    r = '0;
                    r.species = 3'(k);
                    r.value = sq_sums[k];
                    r.last = (k == SPECIES - 1);
                    sq_sums[k] = '0;
                    expected_results.push_back(r);
                end
            end
            ACT_READ:
            begin
                r.species = rsp;
                r.bin_index = rbin;
                if (rsp < SPECIES && rbin < NBINS) r.value = hist_counts[rsp*NBINS+rbin];
                r.last = 1'b1;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] act, input logic [31:0] sx, sy, sz,
                             input logic [31:0] ex, ey, ez, input logic [15:0] q,
                             input logic [2:0] rsp, input logic [5:0] rbin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        action <= act;
        start_x <= sx; start_y <= sy; start_z <= sz;
        end_x <= ex; end_y <= ey; end_z <= ez;
        charge_q <= q;
        read_species <= rsp;
        read_bin <= rbin;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predict_item(act, sx, sy, sz, ex, ey, ez, q, rsp, rbin);
        case (action_t'(act))
            ACT_SAMPLE: samples_sent++;
            ACT_END:    ends_sent++;
            ACT_READ:   reads_sent++;
            default: ;
        endcase
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] sx, sy, sz, ex, ey, ez,
                               input logic [15:0] q);
        send_item(ACT_SAMPLE, sx, sy, sz, ex, ey, ez, q, 3'd0, 6'd0);
    endtask

    task automatic send_end();
        send_item(ACT_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  16'($urandom), 3'($urandom), 6'($urandom));
    endtask

    task automatic send_read(input logic [2:0] rsp, input logic [5:0] rbin);
        send_item(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  16'($urandom), rsp, rbin);
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BOX:  box_reg = data;
            REG_BINW: binw_reg = data;
            REG_MODE: mode_reg = data[2:0];
            default:  fast_reg = data;
        endcase
    endtask

    task automatic configure(input logic [30:0] box, input logic [30:0] binw,
                             input logic [2:0] mode, input logic [30:0] fast);
        drain();
        write_reg(REG_BOX, box);
        write_reg(REG_BINW, binw);
        write_reg(REG_MODE, mode);
        write_reg(REG_FAST, fast);
    endtask

    // Positions near a point so distances land inside the box most of the time.
    task automatic random_sample(input logic [30:0] spread);
        logic [31:0] bx, by, bz;
        logic [15:0] q;
        bx = $urandom; by = $urandom; bz = $urandom;
        q = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3200));
        if ($urandom_range(9) == 0)
            send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, q);
        else
            send_sample(bx, by, bz, bx + $urandom_range(spread) - spread / 2,
                        by + $urandom_range(spread) - spread / 2,
                        bz + $urandom_range(spread) - spread / 2, q);
    endtask

    task automatic test_directed_extremes();
        configure(31'h0004_0000, 31'h0000_1000, MODE_3D, 31'h0000_8000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'd0, 16'd0);
        send_sample(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF);
        send_sample(32'd0, 32'd0, 32'd0, 32'h0000_1000, 32'd0, 32'd0, 16'd767);
        send_sample(32'd0, 32'd0, 32'd0, 32'h0000_9000, 32'd0, 32'd0, 16'd768);
        send_sample(32'd0, 32'd0, 32'd0, 32'h0003_F000, 32'd0, 32'd0, 16'd1791);
        send_sample(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd0, 16'd1792);
        send_sample(32'hFFFF_0000, 32'd0, 32'd0, 32'h0000_0000, 32'd0, 32'd0, 16'd2303);
        send_sample(32'd0, 32'd0, 32'd0, 32'h0003_8000, 32'd0, 32'd0, 16'd2304);
        send_sample(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_0001, 16'd2815);
        send_sample(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd2816);
        send_item(ACT_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_read(3'd0, 6'd0);
        send_read(3'd1, 6'd9);
        send_read(3'd4, 6'd63);
        send_read(3'd5, 6'd1);
        send_read(3'd7, 6'd63);
        send_end();
        send_end();
    endtask

    task automatic test_modes_and_registers();
        for (int m = 0; m < 8; m++)
        begin
            configure(m[0] ? 31'h7FFF_FFFF : 31'h0010_0000, m == 7 ? 31'd0 : 31'h0000_4000,
                      m[2:0], m[1] ? 31'h7FFF_FFFF : 31'd0);
            for (int i = 0; i < 6; i++) random_sample(31'h0010_0000);
            send_read(3'($urandom_range(4)), 6'($urandom_range(63)));
            send_end();
        end
        configure(31'd0, 31'h7FFF_FFFF, MODE_3D, 31'd0);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd100);
        send_sample(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd100);
        send_end();
        // bin width 1 pushes distances of 64 or more past the last bin
        configure(31'h0100_0000, 31'd1, MODE_X, 31'd1);
        for (int i = 0; i < 4; i++) random_sample(31'd200);
        send_end();
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
                configure(31'($urandom_range(31'h0040_0000, 31'h0002_0000)),
                          31'($urandom_range(31'h0001_0000, 31'h0000_0800)),
                          3'($urandom_range(7)), 31'($urandom_range(31'h0002_0000)));
            case ($urandom_range(19))
                0:       send_end();
                1, 2:    send_read(3'($urandom_range(5)), 6'($urandom));
                3:       send_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, 16'($urandom), 3'($urandom),
                                   6'($urandom));
                default: random_sample(31'h0040_0000);
            endcase
        end
        send_end();
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 600;
        for (int i = 0; i < 8; i++) random_sample(31'h0004_0000);
        send_end();
        drain();
        send_read(3'd0, 6'd0);
    endtask

    // check results
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            msd_result_t exp_r;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result species=%0d value=%0h", species, value);
                fail_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (species !== exp_r.species)
                begin
                    $error("species exp %0d got %0d", exp_r.species, species);
                    fail_count++;
                end
                if (sq_distance !== exp_r.sq_distance)
                begin
                    $error("sq_distance exp %0h got %0h", exp_r.sq_distance, sq_distance);
                    fail_count++;
                end
                if (bin_index !== exp_r.bin_index)
                begin
                    $error("bin_index exp %0d got %0d", exp_r.bin_index, bin_index);
                    fail_count++;
                end
                if (binned !== exp_r.binned)
                begin
                    $error("binned exp %0b got %0b", exp_r.binned, binned);
                    fail_count++;
                end
                if (accumulated !== exp_r.accumulated)
                begin
                    $error("accumulated exp %0b got %0b", exp_r.accumulated, accumulated);
                    fail_count++;
                end
                if (value !== exp_r.value)
                begin
                    $error("value exp %0h got %0h", exp_r.value, value);
                    fail_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last exp %0b got %0b", exp_r.last, last);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        box_reg = '0; binw_reg = '0; fast_reg = '0; mode_reg = '0;
        for (int k = 0; k < SPECIES; k++) sq_sums[k] = '0;
        for (int k = 0; k < SPECIES*NBINS; k++) hist_counts[k] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 15; recv_idle_pct = 78;
        test_directed_extremes();
        test_modes_and_registers();
        test_random_traffic(70);

        send_idle_pct = 78; recv_idle_pct = 15;
        test_random_traffic(60);
        test_backpressure();

        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_traffic(60);
        for (int s = 0; s < SPECIES; s++)
            for (int b = 0; b < 4; b++) send_read(s[2:0], 6'($urandom_range(63)));
        drain();

        $display("Covered %0d samples, %0d end items, %0d reads; %0d results checked.",
                 samples_sent, ends_sent, reads_sent, results_seen);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/dha_pkg.sv
rtl/dha_ctrl.sv
rtl/dha_datapath.sv
rtl/displacement_histogram_accumulator_top.sv
sim/tb.sv
